// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/fres_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fres_pkg
// Item types and constants of the refraction and reflectance pipeline.
// ----------------------------------------------------------------------------
package fres_pkg;

	localparam int QUO_BITS = 16;
	localparam int SQRT_STEPS = 29;
	localparam logic [14:0] ONE_Q13 = 15'd8192;
	localparam logic [14:0] RESET_INDEX = 15'd12288;
	localparam logic [15:0] REFL_ONE = 16'd32768;

	typedef struct packed {
		logic signed [15:0] incident_x;
		logic signed [15:0] incident_y;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic               entering;
	} ray_item_t;

	typedef struct packed {
		logic signed [15:0] refracted_x;
		logic signed [15:0] refracted_y;
		logic        [15:0] reflectance;
		logic               total_reflection;
	} res_item_t;

endpackage

// ===== rtl/fres_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fres_div
// Pipelined restoring divider, one quotient bit per stage, 16 bit quotient.
// Needs num < den * 2^16.
// ----------------------------------------------------------------------------
module fres_div
	import fres_pkg::*;
#(
	parameter int NW = 16
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [NW+QUO_BITS-1:0] num,
	input  logic [NW-1:0]          den,
	output logic [QUO_BITS-1:0]    quo
);

	localparam int CW = NW + QUO_BITS;

	logic [CW-1:0]       rem_s [0:QUO_BITS-1];
	logic [NW-1:0]       den_s [0:QUO_BITS-1];
	logic [QUO_BITS-1:0] quo_s [0:QUO_BITS-1];

	for (genvar g = 0; g < QUO_BITS; g++) begin : g_step
		localparam int K = QUO_BITS - 1 - g;
		logic [CW-1:0]       rem_in;
		logic [NW-1:0]       den_in;
		logic [QUO_BITS-1:0] quo_in;
		logic [CW-1:0]       shd;
		logic                ge;

		if (g == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_rest
			assign rem_in = rem_s[g-1];
			assign den_in = den_s[g-1];
			assign quo_in = quo_s[g-1];
		end

		assign shd = CW'(den_in) << K;
		assign ge = rem_in >= shd;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= ge ? rem_in - shd : rem_in;
				den_s[g] <= den_in;
				quo_s[g] <= quo_in | (QUO_BITS'(ge) << K);
			end
		end
	end

	assign quo = quo_s[QUO_BITS-1];

endmodule

// ===== rtl/fresnel_refraction.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fresnel_refraction
// Snell refraction and unpolarized Fresnel reflectance of a 2D ray.
// ----------------------------------------------------------------------------
// Usage:
//   ray channel (ray_valid/ray_ready/ray) takes one hit: incident direction,
//   surface normal and entering flag. res channel (res_valid/res_ready/res)
//   returns refracted direction, reflectance and total reflection flag.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) writes the object index, Q2.13;
//   cfg_ready is always high. Write it only while the pipeline is empty.
//   One item per cycle is accepted while the output does not stall. Depth
//   is set by the 29 stage square root and the 16 stage dividers, one
//   result bit per stage.
//   The whole pipe advances together: while res_valid is high and res_ready
//   low, every stage holds and ray_ready is low; nothing is lost.
//   Reset clears all stage valid bits and sets the index to 1.5.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fresnel_refraction
	import fres_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ray_valid,
	output logic        ray_ready,
	input  ray_item_t   ray,
	output logic        res_valid,
	input  logic        res_ready,
	output res_item_t   res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [14:0] cfg_data
);

	localparam int NSTAGE = 6 + SQRT_STEPS + 3 + QUO_BITS + 2;

	typedef struct packed {
		logic        [28:0] a;
		logic        [28:0] b;
		logic        [14:0] n1;
		logic        [14:0] n2;
		logic signed [16:0] fnx;
		logic signed [16:0] fny;
		logic signed [31:0] n1ix;
		logic signed [31:0] n1iy;
		logic               tir;
	} sq_side_t;

	typedef struct packed {
		logic sx;
		logic sy;
		logic satx;
		logic saty;
		logic rsz;
		logic rpz;
		logic tir;
	} dv_side_t;

	logic [14:0]       index_q;
	logic [14:0]       nclamp;
	logic              en;
	logic [NSTAGE-1:0] valid_pipe_q;

	assign cfg_ready = 1'b1;
	assign en = !res_valid || res_ready;
	assign ray_ready = en;
	assign res_valid = valid_pipe_q[NSTAGE-1];
	assign nclamp = (index_q < ONE_Q13) ? ONE_Q13 : index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= RESET_INDEX;
		end else if (cfg_valid && cfg_ready) begin
			index_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_pipe_q <= '0;
		end else if (en) begin
			valid_pipe_q <= {valid_pipe_q[NSTAGE-2:0], ray_valid};
		end
	end

	// s1: dot products
	logic signed [31:0] px_s1, py_s1;
	logic signed [15:0] ix_s1, iy_s1, nx_s1, ny_s1;
	logic        [14:0] n1_s1, n2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= ray.normal_x * ray.incident_x;
			py_s1 <= ray.normal_y * ray.incident_y;
			ix_s1 <= ray.incident_x;
			iy_s1 <= ray.incident_y;
			nx_s1 <= ray.normal_x;
			ny_s1 <= ray.normal_y;
			n1_s1 <= ray.entering ? ONE_Q13 : nclamp;
			n2_s1 <= ray.entering ? nclamp : ONE_Q13;
		end
	end

	// s2: cosine, normal flip, clamp
	logic signed [32:0] dot;
	logic        [32:0] dmag;
	logic        [28:0] ci_s2;
	logic signed [16:0] fnx_s2, fny_s2;
	logic signed [15:0] ix_s2, iy_s2;
	logic        [14:0] n1_s2, n2_s2;

	assign dot = {px_s1[31], px_s1} + {py_s1[31], py_s1};
	assign dmag = dot[32] ? 33'(-dot) : dot;

	always_ff @(posedge clk) begin
		if (en) begin
			ci_s2 <= (dmag > 33'h1000_0000) ? 29'h1000_0000 : dmag[28:0];
			fnx_s2 <= (dot > 0) ? 17'(-{nx_s1[15], nx_s1}) : {nx_s1[15], nx_s1};
			fny_s2 <= (dot > 0) ? 17'(-{ny_s1[15], ny_s1}) : {ny_s1[15], ny_s1};
			ix_s2 <= ix_s1;
			iy_s2 <= iy_s1;
			n1_s2 <= n1_s1;
			n2_s2 <= n2_s1;
		end
	end

	// s3: squares and scaled cosines
	logic [56:0] ci2_s3;
	logic [29:0] n1sq_s3, n2sq_s3;
	logic [43:0] pa, pb;
	sq_side_t    side_s3;

	assign pa = n1_s2 * ci_s2;
	assign pb = n2_s2 * ci_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ci2_s3 <= ci_s2 * ci_s2;
			n1sq_s3 <= n1_s2 * n1_s2;
			n2sq_s3 <= n2_s2 * n2_s2;
			side_s3.a <= pa[42:14];
			side_s3.b <= pb[42:14];
			side_s3.n1 <= n1_s2;
			side_s3.n2 <= n2_s2;
			side_s3.fnx <= fnx_s2;
			side_s3.fny <= fny_s2;
			side_s3.n1ix <= $signed({1'b0, n1_s2}) * ix_s2;
			side_s3.n1iy <= $signed({1'b0, n1_s2}) * iy_s2;
			side_s3.tir <= 1'b0;
		end
	end

	// s4: sin^2
	logic [28:0] sin2_s4;
	logic [29:0] n1sq_s4, n2sq_s4;
	sq_side_t    side_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sin2_s4 <= 29'h1000_0000 - ci2_s3[56:28];
			n1sq_s4 <= n1sq_s3;
			n2sq_s4 <= n2sq_s3;
			side_s4 <= side_s3;
		end
	end

	// s5: n1^2 * sin^2
	logic [57:0] prod_s5;
	logic [29:0] n2sq_s5;
	sq_side_t    side_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= n1sq_s4 * sin2_s4;
			n2sq_s5 <= n2sq_s4;
			side_s5 <= side_s4;
		end
	end

	// s6: root argument and total reflection
	logic signed [58:0] argd;
	logic        [57:0] arg_s6;
	sq_side_t           side_tir;
	sq_side_t           side_s6;

	assign argd = $signed({1'b0, n2sq_s5, 28'b0}) - $signed({1'b0, prod_s5});

	always_comb begin
		side_tir = side_s5;
		side_tir.tir = argd[58];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			arg_s6 <= argd[57:0];
			side_s6 <= side_tir;
		end
	end

	// square root, one result bit per stage
	logic [57:0] sq_arg_s  [0:SQRT_STEPS-1];
	logic [29:0] sq_rem_s  [0:SQRT_STEPS-1];
	logic [28:0] sq_root_s [0:SQRT_STEPS-1];
	sq_side_t    sq_side_s [0:SQRT_STEPS-1];

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		logic [57:0] arg_in;
		logic [29:0] rem_in;
		logic [28:0] root_in;
		sq_side_t    side_in;
		logic [31:0] cur, trial;
		logic        ge;

		if (j == 0) begin : g_first
			assign arg_in = arg_s6;
			assign rem_in = '0;
			assign root_in = '0;
			assign side_in = side_s6;
		end else begin : g_rest
			assign arg_in = sq_arg_s[j-1];
			assign rem_in = sq_rem_s[j-1];
			assign root_in = sq_root_s[j-1];
			assign side_in = sq_side_s[j-1];
		end

		assign cur = {rem_in, arg_in[57:56]};
		assign trial = {1'b0, root_in, 2'b01};
		assign ge = cur >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[j] <= ge ? 30'(cur - trial) : cur[29:0];
				sq_root_s[j] <= {root_in[27:0], ge};
				sq_arg_s[j] <= {arg_in[55:0], 2'b00};
				sq_side_s[j] <= side_in;
			end
		end
	end

	logic [28:0] w;
	sq_side_t    sd;

	assign w = sq_root_s[SQRT_STEPS-1];
	assign sd = sq_side_s[SQRT_STEPS-1];

	// s7: ratio terms
	logic signed [29:0] amw_s7;
	logic        [29:0] apw_s7;
	logic        [43:0] n1w_s7, n2b_s7;
	logic signed [16:0] fnx_s7, fny_s7;
	logic signed [31:0] n1ix_s7, n1iy_s7;
	logic        [14:0] n2_s7;
	logic               tir_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			amw_s7 <= $signed({1'b0, sd.a}) - $signed({1'b0, w});
			apw_s7 <= {1'b0, sd.a} + {1'b0, w};
			n1w_s7 <= sd.n1 * w;
			n2b_s7 <= sd.n2 * sd.b;
			fnx_s7 <= sd.fnx;
			fny_s7 <= sd.fny;
			n1ix_s7 <= sd.n1ix;
			n1iy_s7 <= sd.n1iy;
			n2_s7 <= sd.n2;
			tir_s7 <= sd.tir;
		end
	end

	// s8: magnitudes and normal terms
	logic signed [44:0] rpd;
	logic signed [29:0] amw_abs;
	logic signed [44:0] rpd_abs;
	logic        [29:0] rs_mag_s8, rs_den_s8;
	logic        [43:0] rp_mag_s8;
	logic        [44:0] rp_den_s8;
	logic signed [46:0] mx_s8, my_s8;
	logic signed [31:0] n1ix_s8, n1iy_s8;
	logic        [14:0] n2_s8;
	logic               tir_s8;

	assign rpd = $signed({1'b0, n1w_s7}) - $signed({1'b0, n2b_s7});
	assign amw_abs = amw_s7[29] ? 30'(-amw_s7) : amw_s7;
	assign rpd_abs = rpd[44] ? 45'(-rpd) : rpd;

	always_ff @(posedge clk) begin
		if (en) begin
			rs_mag_s8 <= amw_abs;
			rs_den_s8 <= apw_s7;
			rp_mag_s8 <= rpd_abs[43:0];
			rp_den_s8 <= {1'b0, n1w_s7} + {1'b0, n2b_s7};
			mx_s8 <= fnx_s7 * amw_s7;
			my_s8 <= fny_s7 * amw_s7;
			n1ix_s8 <= n1ix_s7;
			n1iy_s8 <= n1iy_s7;
			n2_s8 <= n2_s7;
			tir_s8 <= tir_s7;
		end
	end

	// s9: divider operands
	logic signed [47:0] tx, ty;
	logic        [47:0] tmx, tmy;
	logic        [35:0] xx, xy;
	logic        [15:0] dd;
	logic        [31:0] numx_s9, numy_s9;
	logic        [15:0] d_s9;
	logic        [45:0] rsnum_s9;
	logic        [29:0] rsden_s9;
	logic        [60:0] rpnum_s9;
	logic        [44:0] rpden_s9;
	dv_side_t           dside_s9;

	assign tx = {{2{n1ix_s8[31]}}, n1ix_s8, 14'b0} + {mx_s8[46], mx_s8};
	assign ty = {{2{n1iy_s8[31]}}, n1iy_s8, 14'b0} + {my_s8[46], my_s8};
	assign tmx = tx[47] ? 48'(-tx) : tx;
	assign tmy = ty[47] ? 48'(-ty) : ty;
	assign xx = {1'b0, tmx[47:13]} + {21'b0, n2_s8};
	assign xy = {1'b0, tmy[47:13]} + {21'b0, n2_s8};
	assign dd = {n2_s8, 1'b0};

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s9 <= xx[31:0];
			numy_s9 <= xy[31:0];
			d_s9 <= dd;
			rsnum_s9 <= {1'b0, rs_mag_s8, 15'b0};
			rsden_s9 <= rs_den_s8;
			rpnum_s9 <= {2'b0, rp_mag_s8, 15'b0};
			rpden_s9 <= rp_den_s8;
			dside_s9.sx <= tx[47];
			dside_s9.sy <= ty[47];
			dside_s9.satx <= xx[35:16] >= {4'b0, dd};
			dside_s9.saty <= xy[35:16] >= {4'b0, dd};
			dside_s9.rsz <= rs_den_s8 == '0;
			dside_s9.rpz <= rp_den_s8 == '0;
			dside_s9.tir <= tir_s8;
		end
	end

	logic [QUO_BITS-1:0] qx, qy, qrs, qrp;

	fres_div #(.NW(16)) u_div_x (.clk, .en, .num(numx_s9), .den(d_s9), .quo(qx));
	fres_div #(.NW(16)) u_div_y (.clk, .en, .num(numy_s9), .den(d_s9), .quo(qy));
	fres_div #(.NW(30)) u_div_rs (.clk, .en, .num(rsnum_s9), .den(rsden_s9), .quo(qrs));
	fres_div #(.NW(45)) u_div_rp (.clk, .en, .num(rpnum_s9), .den(rpden_s9), .quo(qrp));

	dv_side_t dv_side_s [0:QUO_BITS-1];

	for (genvar g = 0; g < QUO_BITS; g++) begin : g_dside
		always_ff @(posedge clk) begin
			if (en) begin
				dv_side_s[g] <= (g == 0) ? dside_s9 : dv_side_s[(g == 0) ? 0 : g - 1];
			end
		end
	end

	function automatic logic [15:0] sat_dir(input logic [15:0] q, input logic s,
			input logic sat);
		logic [15:0] r;
		if (sat) begin
			r = s ? 16'h8000 : 16'h7fff;
		end else if (!s) begin
			r = (q > 16'h7fff) ? 16'h7fff : q;
		end else begin
			r = (q > 16'h8000) ? 16'h8000 : 16'(17'd0 - {1'b0, q});
		end
		return r;
	endfunction

	// s10: squares and direction saturation
	dv_side_t           dq;
	logic        [30:0] rs_sq, rp_sq;
	logic        [30:0] rs_sq_s10, rp_sq_s10;
	logic signed [15:0] rx_s10, ry_s10;
	logic               tir_s10;

	assign dq = dv_side_s[QUO_BITS-1];
	assign rs_sq = qrs * qrs;
	assign rp_sq = qrp * qrp;

	always_ff @(posedge clk) begin
		if (en) begin
			rs_sq_s10 <= dq.rsz ? 31'h4000_0000 : rs_sq;
			rp_sq_s10 <= dq.rpz ? 31'h4000_0000 : rp_sq;
			rx_s10 <= sat_dir(qx, dq.sx, dq.satx);
			ry_s10 <= sat_dir(qy, dq.sy, dq.saty);
			tir_s10 <= dq.tir;
		end
	end

	// s11: output register
	logic [31:0] rsum;
	logic [16:0] rr;
	res_item_t   res_s11;

	assign rsum = {1'b0, rs_sq_s10} + {1'b0, rp_sq_s10} + 32'd32768;
	assign rr = rsum[31:15] >> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			res_s11.total_reflection <= tir_s10;
			res_s11.refracted_x <= tir_s10 ? 16'sd0 : rx_s10;
			res_s11.refracted_y <= tir_s10 ? 16'sd0 : ry_s10;
			if (tir_s10 || rr > {1'b0, REFL_ONE}) begin
				res_s11.reflectance <= REFL_ONE;
			end else begin
				res_s11.reflectance <= rr[15:0];
			end
		end
	end

	assign res = res_s11;

	logic tir_ok;

	assign tir_ok = res.refracted_x == 16'sd0 && res.refracted_y == 16'sd0
		&& res.reflectance == REFL_ONE;

	`ASSERT_IMPLIES(a_tir_out, res_valid && res.total_reflection, tir_ok, "tir item not forced")
	`ASSERT_IMPLIES(a_refl_max, res_valid, res.reflectance <= REFL_ONE, "reflectance above 1.0")
	`ASSERT_NEXT(a_hold, !ray_ready, $stable(valid_pipe_q), "pipeline moved while stalled")

endmodule
